// ===== src/dpb_pkg.sv =====
// ---------------------------------------------------------------------------
// dpb_pkg
// Shared constants for the depth pixel back-projection block.
// ---------------------------------------------------------------------------
package dpb_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int DEPTH_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int XY_W      = 40;
  localparam int Z_W       = 32;
  localparam int FIFO_DEPTH = 4;

  localparam int COORD_BITS_DEF     = 12;
  localparam int FRAC_BITS_DEF      = 16;
  localparam int SUBSAMPLE_STEP_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y     = 3'd4;

  localparam logic [CFG_W-1:0] RST_DEPTH_SCALE = 16'd1000;
  localparam logic [CFG_W-1:0] RST_CENTER_X    = 16'd5112;
  localparam logic [CFG_W-1:0] RST_CENTER_Y    = 16'd3832;
  localparam logic [CFG_W-1:0] RST_FOCAL_X     = 16'd8400;
  localparam logic [CFG_W-1:0] RST_FOCAL_Y     = 16'd8400;

  localparam logic [XY_W-1:0] XY_MAX = {1'b0, {(XY_W-1){1'b1}}};
  localparam logic [XY_W-1:0] XY_MIN = {1'b1, {(XY_W-1){1'b0}}};
  localparam logic [Z_W-1:0]  Z_MAX  = {Z_W{1'b1}};

endpackage

// ===== src/dpb_udiv.sv =====
// ---------------------------------------------------------------------------
// dpb_udiv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module dpb_udiv import dpb_pkg::*; #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]  vld_q;
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [NUM_W-1:0]  quo_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  logic [DEN_W-1:0]  rem_d  [NUM_W];
  logic [NUM_W-1:0]  num_d  [NUM_W];
  logic [NUM_W-1:0]  quo_d  [NUM_W];

  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rp;
    logic [NUM_W-1:0] np;
    logic [NUM_W-1:0] qp;
    for (int s = 0; s < NUM_W; s++) begin
      if (s == 0) begin
        rp = '0;
        np = num_i;
        qp = '0;
      end else begin
        rp = rem_q[s-1];
        np = num_q[s-1];
        qp = quo_q[s-1];
      end
      trial = {rp, np[NUM_W-1]};
      num_d[s] = np << 1;
      if (trial >= {1'b0, den_i}) begin
        rem_d[s] = DEN_W'(trial - {1'b0, den_i});
        quo_d[s] = {qp[NUM_W-2:0], 1'b1};
      end else begin
        rem_d[s] = DEN_W'(trial);
        quo_d[s] = {qp[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NUM_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NUM_W; s++) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
        quo_q[s] <= quo_d[s];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

// ===== src/dpb_front.sv =====
// ---------------------------------------------------------------------------
// dpb_front
// Accepts pixels, drops off-grid and empty ones, queues the rest.
// ---------------------------------------------------------------------------
module dpb_front import dpb_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int SUBSAMPLE_STEP = SUBSAMPLE_STEP_DEF,
  parameter int MW             = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] pixel_row_i,
  input  logic [COORD_BITS-1:0] pixel_col_i,
  input  logic [DEPTH_W-1:0]    depth_value_i,
  input  logic [COLOR_W-1:0]    blue_in_i,
  input  logic [COLOR_W-1:0]    green_in_i,
  input  logic [COLOR_W-1:0]    red_in_i,
  input  logic [CFG_W-1:0]      center_x_i,
  input  logic [CFG_W-1:0]      center_y_i,
  input  logic                  rd_i,
  output logic                  empty_o,
  output logic [MW-1:0]         mag_x_o,
  output logic                  neg_x_o,
  output logic [MW-1:0]         mag_y_o,
  output logic                  neg_y_o,
  output logic [DEPTH_W-1:0]    depth_o,
  output logic [3*COLOR_W-1:0]  color_o
);

  localparam int DIFF_W  = MW + 1;
  localparam int SH      = COORD_BITS + 4;
  localparam int RECIP   = ((1 << SH) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP;
  localparam int PROD_W  = 2 * COORD_BITS + 6;
  localparam int ENTRY_W = 2 * (MW + 1) + DEPTH_W + 3 * COLOR_W;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);

  logic [PROD_W-1:0]     prod_row, prod_col;
  logic [COORD_BITS-1:0] q_row, q_col;
  logic                  keep;
  logic [DIFF_W-1:0]     diff_x, diff_y;
  logic [MW-1:0]         mx, my;
  logic [ENTRY_W-1:0]    entry;
  logic                  wr, rd;

  logic [ENTRY_W-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     cnt_q;

  // grid test through a reciprocal multiply
  assign prod_row = PROD_W'(pixel_row_i) * PROD_W'(RECIP);
  assign prod_col = PROD_W'(pixel_col_i) * PROD_W'(RECIP);
  assign q_row    = prod_row[SH +: COORD_BITS];
  assign q_col    = prod_col[SH +: COORD_BITS];
  assign keep = (depth_value_i != '0)
              && (pixel_row_i == COORD_BITS'(q_row * COORD_BITS'(SUBSAMPLE_STEP)))
              && (pixel_col_i == COORD_BITS'(q_col * COORD_BITS'(SUBSAMPLE_STEP)));

  assign diff_x = DIFF_W'({pixel_col_i, 4'b0}) - DIFF_W'(center_x_i);
  assign diff_y = DIFF_W'({pixel_row_i, 4'b0}) - DIFF_W'(center_y_i);
  assign mx = diff_x[DIFF_W-1] ? MW'(-diff_x) : diff_x[MW-1:0];
  assign my = diff_y[DIFF_W-1] ? MW'(-diff_y) : diff_y[MW-1:0];

  assign entry = {mx, diff_x[DIFF_W-1], my, diff_y[DIFF_W-1], depth_value_i,
                  blue_in_i, green_in_i, red_in_i};

  assign full    = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push && !full && keep;
  assign rd      = rd_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wr_ptr_q] <= entry;
  end

  assign {mag_x_o, neg_x_o, mag_y_o, neg_y_o, depth_o, color_o} = mem_q[rd_ptr_q];

endmodule

// ===== src/dpb_back.sv =====
// ---------------------------------------------------------------------------
// dpb_back
// Depth divide, coordinate multiply, focal divides, saturation, output word.
// ---------------------------------------------------------------------------
module dpb_back import dpb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MW        = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  output logic                 q_rd_o,
  input  logic [MW-1:0]        mag_x_i,
  input  logic                 neg_x_i,
  input  logic [MW-1:0]        mag_y_i,
  input  logic                 neg_y_i,
  input  logic [DEPTH_W-1:0]   depth_i,
  input  logic [3*COLOR_W-1:0] color_i,
  input  logic [CFG_W-1:0]     depth_scale_i,
  input  logic [CFG_W-1:0]     focal_x_i,
  input  logic [CFG_W-1:0]     focal_y_i,
  input  logic                 pop,
  output logic                 empty,
  output logic [XY_W-1:0]      point_x_o,
  output logic [XY_W-1:0]      point_y_o,
  output logic [Z_W-1:0]       point_z_o,
  output logic [3*COLOR_W-1:0] color_o
);

  localparam int ZN_W  = DEPTH_W + FRAC_BITS;
  localparam int S1_W  = 2 * (MW + 1) + 3 * COLOR_W;
  localparam int PW    = MW + Z_W;
  localparam int SX_W  = Z_W + 3 * COLOR_W + 2;

  logic en;

  logic              zv;
  logic [ZN_W-1:0]   zq;
  logic [S1_W-1:0]   s1;
  logic [Z_W-1:0]    zsat;
  logic [MW-1:0]     s1_mx, s1_my;
  logic              s1_nx, s1_ny;
  logic [3*COLOR_W-1:0] s1_col;

  logic              m_vld_q;
  logic [PW-1:0]     px_q, py_q;
  logic              nx_q, ny_q;
  logic [Z_W-1:0]    mz_q;
  logic [3*COLOR_W-1:0] mcol_q;

  logic              xv, yv;
  logic [PW-1:0]     xq, yq;
  logic [SX_W-1:0]   sx;
  logic [1:0]        sy;
  logic [XY_W-1:0]   xs, ys;

  logic              out_vld_q;
  logic [XY_W-1:0]   x_q, y_q;
  logic [Z_W-1:0]    z_q;
  logic [3*COLOR_W-1:0] col_q;

  // whole pipeline moves together while the output word is empty or being popped
  assign en     = !out_vld_q || pop;
  assign q_rd_o = en && !q_empty_i;

  dpb_udiv #(.NUM_W(ZN_W), .DEN_W(CFG_W), .SIDE_W(S1_W)) u_zdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(!q_empty_i),
    .num_i(ZN_W'(depth_i) << FRAC_BITS), .den_i(depth_scale_i),
    .side_i({mag_x_i, neg_x_i, mag_y_i, neg_y_i, color_i}),
    .valid_o(zv), .quo_o(zq), .side_o(s1)
  );

  assign {s1_mx, s1_nx, s1_my, s1_ny, s1_col} = s1;
  assign zsat = (zq > ZN_W'(Z_MAX)) ? Z_MAX : Z_W'(zq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= zv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= PW'(s1_mx) * PW'(zsat);
      py_q   <= PW'(s1_my) * PW'(zsat);
      nx_q   <= s1_nx;
      ny_q   <= s1_ny;
      mz_q   <= zsat;
      mcol_q <= s1_col;
    end
  end

  dpb_udiv #(.NUM_W(PW), .DEN_W(CFG_W), .SIDE_W(SX_W)) u_xdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m_vld_q),
    .num_i(px_q), .den_i(focal_x_i),
    .side_i({mz_q, mcol_q, nx_q, (px_q == '0)}),
    .valid_o(xv), .quo_o(xq), .side_o(sx)
  );

  dpb_udiv #(.NUM_W(PW), .DEN_W(CFG_W), .SIDE_W(2)) u_ydiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m_vld_q),
    .num_i(py_q), .den_i(focal_y_i),
    .side_i({ny_q, (py_q == '0)}),
    .valid_o(yv), .quo_o(yq), .side_o(sy)
  );

  // sign-magnitude back to saturated two's complement
  function automatic logic [XY_W-1:0] sat_xy(input logic [PW-1:0] q, input logic neg,
                                             input logic zero);
    logic [XY_W-1:0] r;
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (q > PW'(XY_MAX)) ? XY_MAX : XY_W'(q);
    end else begin
      r = (q > PW'(XY_MIN)) ? XY_MIN : XY_W'(-q);
    end
    return r;
  endfunction

  assign xs = sat_xy(xq, sx[1], sx[0]);
  assign ys = sat_xy(yq, sy[1], sy[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= xv && yv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q   <= xs;
      y_q   <= ys;
      z_q   <= sx[SX_W-1 -: Z_W];
      col_q <= sx[2 +: 3*COLOR_W];
    end
  end

  assign empty     = !out_vld_q;
  assign point_x_o = x_q;
  assign point_y_o = y_q;
  assign point_z_o = z_q;
  assign color_o   = col_q;

endmodule

// ===== src/depth_pixel_backprojection.sv =====
// ---------------------------------------------------------------------------
// depth_pixel_backprojection
// Back-projects subsampled RGB-D pixels through a pinhole camera model.
// ---------------------------------------------------------------------------
// channel  direction  handshake                 payload
// pixel    in         push / full               row, col, depth, b, g, r
// point    out        empty / pop               x, y, z, b, g, r
// config   in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one pixel accepted per cycle while full is low; a kept pixel passes in order the
// bit-per-stage depth divider, the multiply register, the bit-per-stage focal
// dividers and the output register; dropped pixels leave the block on acceptance;
// a four-word queue sits between the classifier and the arithmetic pipeline,
// which stalls as one while a held output word waits for pop
// reset clears the queue, pipeline valid bits and loads the register defaults
// ---------------------------------------------------------------------------
module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int SUBSAMPLE_STEP = SUBSAMPLE_STEP_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] pixel_row_i,
  input  logic [COORD_BITS-1:0] pixel_col_i,
  input  logic [DEPTH_W-1:0]    depth_value_i,
  input  logic [COLOR_W-1:0]    blue_in_i,
  input  logic [COLOR_W-1:0]    green_in_i,
  input  logic [COLOR_W-1:0]    red_in_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [XY_W-1:0]       point_x_o,
  output logic [XY_W-1:0]       point_y_o,
  output logic [Z_W-1:0]        point_z_o,
  output logic [COLOR_W-1:0]    blue_out_o,
  output logic [COLOR_W-1:0]    green_out_o,
  output logic [COLOR_W-1:0]    red_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int MW = ((COORD_BITS + 4) > 16) ? (COORD_BITS + 4) : 16;

  logic [CFG_W-1:0] scale_q, cx_q, cy_q, fx_q, fy_q;

  logic                 q_empty, q_rd;
  logic [MW-1:0]        mag_x, mag_y;
  logic                 neg_x, neg_y;
  logic [DEPTH_W-1:0]   q_depth;
  logic [3*COLOR_W-1:0] q_color, out_color;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= RST_DEPTH_SCALE;
      cx_q    <= RST_CENTER_X;
      cy_q    <= RST_CENTER_Y;
      fx_q    <= RST_FOCAL_X;
      fy_q    <= RST_FOCAL_Y;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEPTH_SCALE: scale_q <= cfg_data_i;
        REG_CENTER_X:    cx_q    <= cfg_data_i;
        REG_CENTER_Y:    cy_q    <= cfg_data_i;
        REG_FOCAL_X:     fx_q    <= cfg_data_i;
        REG_FOCAL_Y:     fy_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dpb_front #(
    .COORD_BITS(COORD_BITS), .SUBSAMPLE_STEP(SUBSAMPLE_STEP), .MW(MW)
  ) u_front (
    .clk_i, .rst_ni, .push, .full,
    .pixel_row_i, .pixel_col_i, .depth_value_i, .blue_in_i, .green_in_i, .red_in_i,
    .center_x_i(cx_q), .center_y_i(cy_q),
    .rd_i(q_rd), .empty_o(q_empty),
    .mag_x_o(mag_x), .neg_x_o(neg_x), .mag_y_o(mag_y), .neg_y_o(neg_y),
    .depth_o(q_depth), .color_o(q_color)
  );

  dpb_back #(.FRAC_BITS(FRAC_BITS), .MW(MW)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_rd_o(q_rd),
    .mag_x_i(mag_x), .neg_x_i(neg_x), .mag_y_i(mag_y), .neg_y_i(neg_y),
    .depth_i(q_depth), .color_i(q_color),
    .depth_scale_i(scale_q), .focal_x_i(fx_q), .focal_y_i(fy_q),
    .pop, .empty,
    .point_x_o, .point_y_o, .point_z_o, .color_o(out_color)
  );

  assign {blue_out_o, green_out_o, red_out_o} = out_color;

  // a kept pixel has nonzero depth, so z never comes out as zero
  a_z_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> point_z_o != '0) else $error("zero z on a delivered point");

  // the pipeline only draws words that the queue holds
  a_rd_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_empty) else $error("queue read while empty");

  // queue cannot be full and empty at once
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && q_empty)) else $error("queue full and empty together");

endmodule

// ===== verif/tb_depth_pixel_backprojection.sv =====
// ---------------------------------------------------------------------------
// tb_depth_pixel_backprojection
// Streams RGB-D pixels through the back-projection block under several camera
// settings, predicts each kept point in fixed point and checks it word by word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection;
  import dpb_pkg::*;

  localparam int RW = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int STEP = SUBSAMPLE_STEP_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [RW-1:0]      row;
    logic [RW-1:0]      col;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] b, g, r;
  } pixel_t;

  typedef struct packed {
    logic [XY_W-1:0]    x, y;
    logic [Z_W-1:0]     z;
    logic [COLOR_W-1:0] b, g, r;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, cfg_ready_o;
  logic [RW-1:0]        pixel_row_i = '0, pixel_col_i = '0;
  logic [DEPTH_W-1:0]   depth_value_i = '0;
  logic [COLOR_W-1:0]   blue_in_i = '0, green_in_i = '0, red_in_i = '0;
  logic [XY_W-1:0]      point_x_o, point_y_o;
  logic [Z_W-1:0]       point_z_o;
  logic [COLOR_W-1:0]   blue_out_o, green_out_o, red_out_o;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_DEPTH_SCALE;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // camera settings as the block should hold them
  logic [CFG_W-1:0] cam_scale = RST_DEPTH_SCALE;
  logic [CFG_W-1:0] cam_cx = RST_CENTER_X, cam_cy = RST_CENTER_Y;
  logic [CFG_W-1:0] cam_fx = RST_FOCAL_X, cam_fy = RST_FOCAL_Y;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  pixel_t cur_pixel;
  int     send_gap = 0, pop_gap = 0, hold_cnt = 0;
  int     pixels_taken = 0, mismatches = 0, cycles = 0;
  bit     long_hold_done = 0, no_idle = 0;

  depth_pixel_backprojection DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // (pos*16 - centre) * z / focal, truncated toward zero, saturated to 40 bits
  function automatic logic [XY_W-1:0] project(logic [RW-1:0] pos, logic [CFG_W-1:0] centre,
                                              logic [Z_W-1:0] z, logic [CFG_W-1:0] focal);
    longint diff, num, q;
    diff = longint'(pos) * 16 - longint'(centre);
    num = diff * longint'({32'b0, z});
    if (focal == 0) begin
      if (num > 0) return XY_MAX;
      if (num < 0) return XY_MIN;
      return '0;
    end
    q = num / longint'(focal);
    if (q > 64'sh7F_FFFF_FFFF) return XY_MAX;
    if (q < -64'sh80_0000_0000) return XY_MIN;
    return q[XY_W-1:0];
  endfunction

  function automatic bit backproject(pixel_t p, output point_t pt);
    logic [47:0] zq;
    if (p.depth == 0 || (p.row % STEP) != 0 || (p.col % STEP) != 0) return 0;
    if (cam_scale == 0) pt.z = Z_MAX;
    else begin
      zq = ({32'b0, p.depth} << FB) / cam_scale;
      pt.z = (zq > 48'hFFFF_FFFF) ? Z_MAX : zq[Z_W-1:0];
    end
    pt.x = project(p.col, cam_cx, pt.z, cam_fx);
    pt.y = project(p.row, cam_cy, pt.z, cam_fy);
    pt.b = p.b;
    pt.g = p.g;
    pt.r = p.r;
    return 1;
  endfunction

  // mostly kept pixels with random content, the rest random positions, a third with no depth
  function automatic pixel_t random_pixel();
    pixel_t p;
    p = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 75) begin
      p.row[0] = 1'b0;
      p.col[0] = 1'b0;
      if (p.depth == 0) p.depth = DEPTH_W'(1);
      if ($urandom_range(0, 3) == 0) p.depth = DEPTH_W'($urandom_range(1, 3000));
    end else if ($urandom_range(0, 2) == 0) p.depth = '0;
    return p;
  endfunction

  // sender
  always @(posedge clk_i) begin
    point_t pt;
    if (push && !full) begin
      pixels_taken++;
      if (backproject(cur_pixel, pt)) expected_points = {expected_points, pt};
    end
    if (!push || !full) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (rst_ni && pending_pixels.size() > 0) begin
        cur_pixel = pending_pixels.pop_front();
        pixel_row_i <= cur_pixel.row;
        pixel_col_i <= cur_pixel.col;
        depth_value_i <= cur_pixel.depth;
        blue_in_i <= cur_pixel.b;
        green_in_i <= cur_pixel.g;
        red_in_i <= cur_pixel.r;
        push <= 1'b1;
        send_gap = next_gap();
      end else push <= 1'b0;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    point_t got, want;
    if (pop && !empty) begin
      got = {point_x_o, point_y_o, point_z_o, blue_out_o, green_out_o, red_out_o};
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point word %h", got);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: x %h/%h y %h/%h z %h/%h bgr %h%h%h/%h%h%h",
                     want.x, got.x, want.y, got.y, want.z, got.z,
                     want.b, want.g, want.r, got.b, got.g, got.r);
        end
      end
    end
    if (!long_hold_done && pixels_taken >= 200) begin
      // long back-pressure so the pipeline fills and full rises
      long_hold_done = 1;
      hold_cnt = 400;
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_gap = next_gap();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[depth_pixel_backprojection] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || push || expected_points.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DEPTH_SCALE: cam_scale = val;
      REG_CENTER_X:    cam_cx = val;
      REG_CENTER_Y:    cam_cy = val;
      REG_FOCAL_X:     cam_fx = val;
      default:         cam_fy = val;
    endcase
  endtask

  task automatic set_camera(int s, int cx, int cy, int fx, int fy);
    wait_idle();
    write_reg(REG_DEPTH_SCALE, CFG_W'(s));
    write_reg(REG_CENTER_X, CFG_W'(cx));
    write_reg(REG_CENTER_Y, CFG_W'(cy));
    write_reg(REG_FOCAL_X, CFG_W'(fx));
    write_reg(REG_FOCAL_Y, CFG_W'(fy));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_pixel(int row, int col, int depth, int b, int g, int r);
    pixel_t p;
    p.row = RW'(row);
    p.col = RW'(col);
    p.depth = DEPTH_W'(depth);
    p.b = COLOR_W'(b);
    p.g = COLOR_W'(g);
    p.r = COLOR_W'(r);
    pending_pixels = {pending_pixels, p};
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_pixels = {pending_pixels, random_pixel()};
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // default camera: corners, drops, depth extremes, colour extremes
    queue_pixel(0, 0, 1, 0, 0, 0);
    queue_pixel(4094, 4094, 65535, 255, 255, 255);
    queue_pixel(0, 4094, 65535, 1, 2, 3);
    queue_pixel(4094, 0, 1000, 255, 0, 128);
    queue_pixel(240, 320, 0, 9, 9, 9);
    queue_pixel(241, 320, 500, 8, 8, 8);
    queue_pixel(240, 321, 500, 7, 7, 7);
    queue_pixel(4095, 4095, 65535, 6, 6, 6);
    queue_pixel(238, 320, 1500, 10, 20, 30);
    queue_random(180);
    // extremes: unit scale and unit x focal length drive x into saturation
    set_camera(1, 0, 65535, 1, 65535);
    queue_pixel(4094, 4094, 65535, 1, 1, 1);
    queue_pixel(0, 0, 65535, 2, 2, 2);
    queue_pixel(2, 2, 1, 3, 3, 3);
    queue_random(190);
    set_camera(65535, 65535, 0, 65535, 1);
    queue_pixel(0, 0, 65535, 4, 4, 4);
    queue_pixel(4094, 4094, 1, 5, 5, 5);
    queue_random(190);
    // zero scale and zero focal lengths, with the centre on a kept pixel
    set_camera(0, 320, 3840, 0, 0);
    queue_pixel(240, 20, 77, 11, 12, 13);
    queue_pixel(240, 10, 77, 14, 15, 16);
    queue_pixel(250, 30, 77, 17, 18, 19);
    queue_random(150);
    set_camera(1000, 5112, 3832, 8400, 8400);
    no_idle = 1;
    queue_random(150);
    wait_idle();
    no_idle = 0;
    repeat (3) begin
      set_camera($urandom_range(1, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(1, 65535), $urandom_range(1, 65535));
      queue_random(160);
    end
    wait_idle();
    if (mismatches == 0) $display("[depth_pixel_backprojection] OK");
    else $display("[depth_pixel_backprojection] ERROR");
    $finish;
  end

endmodule
